FILE: sv/artc_pkg.sv
`timescale 1ns / 1ps

package artc_pkg;

    localparam int REGIONS_DEFAULT = 16;

    localparam int ADDR_W      = 48;
    localparam int END_W       = ADDR_W + 1;
    localparam int OP_W        = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int TOTAL_W     = 64;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // One stored region; the end is kept as the exact 49-bit sum of start and length.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [END_W-1:0]  stop;
    } artc_entry_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic            compare;
        logic            apply;
        logic [OP_W-1:0] op;
    } artc_ctrl_t;

endpackage

FILE: sv/artc_cell.sv
`timescale 1ns / 1ps

module artc_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  artc_pkg::artc_ctrl_t         ctrl,
    input  logic [artc_pkg::ADDR_W-1:0]  addr,
    input  logic [artc_pkg::END_W-1:0]   check_end,
    input  logic                         prev_valid,
    input  logic                         found_in,
    input  logic                         hit_in,
    input  artc_pkg::artc_entry_t        upper,
    output logic                         found_out,
    output logic                         hit_out,
    output artc_pkg::artc_entry_t        entry
);
    import artc_pkg::*;

    logic              valid_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [END_W-1:0]  stop_reg;
    logic              match_reg;
    logic              contain_reg;

    logic              write_en;
    logic              shift_en;

    assign entry = '{valid: valid_reg, start: start_reg, stop: stop_reg};

    // The lowest matching cell and every cell above it take their upper neighbor.
    assign found_out = found_in | match_reg;
    assign hit_out   = hit_in | contain_reg;

    assign write_en = ctrl.apply && (ctrl.op == OP_ADD) && !valid_reg && prev_valid;
    assign shift_en = ctrl.apply && (ctrl.op == OP_REMOVE) && found_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            match_reg   <= 1'b0;
            contain_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.compare)
            begin
                match_reg   <= valid_reg && (start_reg == addr);
                contain_reg <= valid_reg && (addr >= start_reg) && (check_end <= stop_reg);
            end
            if (write_en)
            begin
                valid_reg <= 1'b1;
            end
            else if (shift_en)
            begin
                valid_reg <= upper.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            start_reg <= addr;
            stop_reg  <= check_end;
        end
        else if (shift_en)
        begin
            start_reg <= upper.start;
            stop_reg  <= upper.stop;
        end
    end

endmodule

FILE: sv/address_region_table_checker.sv
`timescale 1ns / 1ps
// A command taken at a clock edge passes through a compare cycle (busy) and an apply cycle;
// its result is then registered on the outputs, with done high.
// A new command can be taken before the last one is through: busy is high for the compare cycle, and the
// apply cycle of the chain of region cells overlaps the next command's acceptance.
// Reset clears the region count, both totals and all cell valid bits; no pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module address_region_table_checker #(
    parameter int REGIONS = artc_pkg::REGIONS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [artc_pkg::OP_W-1:0]         operation,
    input  logic [artc_pkg::ADDR_W-1:0]       address,
    input  logic [artc_pkg::ADDR_W-1:0]       length,
    output logic                              done,
    output logic                              in_region,
    output logic                              add_dropped,
    output logic                              removed,
    output logic [artc_pkg::COUNT_OUT_W-1:0]  region_count,
    output logic [artc_pkg::TOTAL_W-1:0]      checks_seen,
    output logic [artc_pkg::TOTAL_W-1:0]      checks_hit
);
    import artc_pkg::*;

    localparam int CW = $clog2(REGIONS + 1);

    logic              busy_reg;
    logic              apply_reg;
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [END_W-1:0]  end_reg;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [TOTAL_W-1:0] check_total_reg;
    logic [TOTAL_W-1:0] hit_total_reg;

    logic done_reg;
    logic in_region_reg;
    logic add_dropped_reg;
    logic removed_reg;

    logic        accept;
    logic        full;
    artc_ctrl_t  ctrl;

    logic [REGIONS:0]    found_chain;
    logic [REGIONS:0]    hit_chain;
    logic [REGIONS-1:0]  valid_vec;
    artc_entry_t         entries [REGIONS];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign full   = (count_reg == CW'(REGIONS));

    assign ctrl = '{compare: busy_reg, apply: apply_reg, op: op_reg};

    assign found_chain[0] = 1'b0;
    assign hit_chain[0]   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < REGIONS; gi++)
        begin : g_cell
            logic        prev_valid;
            artc_entry_t upper;

            if (gi == 0)
            begin : g_first
                assign prev_valid = 1'b1;
            end
            else
            begin : g_rest
                assign prev_valid = entries[gi-1].valid;
            end

            if (gi == REGIONS - 1)
            begin : g_last
                assign upper = '0;
            end
            else
            begin : g_inner
                assign upper = entries[gi+1];
            end

            artc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .addr       (addr_reg),
                .check_end  (end_reg),
                .prev_valid (prev_valid),
                .found_in   (found_chain[gi]),
                .hit_in     (hit_chain[gi]),
                .upper      (upper),
                .found_out  (found_chain[gi+1]),
                .hit_out    (hit_chain[gi+1]),
                .entry      (entries[gi])
            );

            assign valid_vec[gi] = entries[gi].valid;
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if ((op_reg == OP_ADD) && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        else if ((op_reg == OP_REMOVE) && found_chain[REGIONS])
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            addr_reg <= address;
            end_reg  <= {1'b0, address} + {1'b0, length};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            apply_reg       <= 1'b0;
            count_reg       <= '0;
            check_total_reg <= '0;
            hit_total_reg   <= '0;
            done_reg        <= 1'b0;
            in_region_reg   <= 1'b0;
            add_dropped_reg <= 1'b0;
            removed_reg     <= 1'b0;
        end
        else
        begin
            busy_reg  <= accept;
            apply_reg <= busy_reg;
            done_reg  <= apply_reg;
            if (apply_reg)
            begin
                count_reg       <= count_next;
                in_region_reg   <= (op_reg == OP_CHECK) && hit_chain[REGIONS];
                add_dropped_reg <= (op_reg == OP_ADD) && full;
                removed_reg     <= (op_reg == OP_REMOVE) && found_chain[REGIONS];
                if (op_reg == OP_CHECK)
                begin
                    check_total_reg <= check_total_reg + TOTAL_W'(1);
                    if (hit_chain[REGIONS])
                    begin
                        hit_total_reg <= hit_total_reg + TOTAL_W'(1);
                    end
                end
            end
        end
    end

    assign done         = done_reg;
    assign in_region    = in_region_reg;
    assign add_dropped  = add_dropped_reg;
    assign removed      = removed_reg;
    assign region_count = COUNT_OUT_W'(count_reg);
    assign checks_seen  = check_total_reg;
    assign checks_hit   = hit_total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(REGIONS))
        else $error("region count exceeds table size");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("cell valid bits disagree with region count");

    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> apply_reg && !busy_reg)
        else $error("compare cycle not followed by apply cycle");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && removed_reg |-> $past(count_reg) == count_reg + CW'(1))
        else $error("remove transfer did not lower the count by one");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && add_dropped_reg |-> count_reg == CW'(REGIONS))
        else $error("add dropped while table not full");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    import artc_pkg::*;

    typedef struct packed {
        logic                   hit;
        logic                   dropped;
        logic                   gone;
        logic [COUNT_OUT_W-1:0] count;
        logic [TOTAL_W-1:0]     seen;
        logic [TOTAL_W-1:0]     hits;
    } region_result_t;

    class region_scoreboard;
        logic [ADDR_W-1:0]  starts [REGIONS_DEFAULT];
        logic [ADDR_W-1:0]  lengths [REGIONS_DEFAULT];
        int unsigned        used;
        logic [TOTAL_W-1:0] check_total;
        logic [TOTAL_W-1:0] hit_total;
        region_result_t     expected_q [$];
        int                 errors;
        int                 n_add, n_dropped, n_remove, n_removed, n_check, n_noop, peak;

        function new();
            used = 0;
            check_total = '0;
            hit_total = '0;
            errors = 0;
            n_add = 0;
            n_dropped = 0;
            n_remove = 0;
            n_removed = 0;
            n_check = 0;
            n_noop = 0;
            peak = 0;
        endfunction

        // Updates the table for one accepted command and queues its result.
        function void note_command(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] len);
            region_result_t r;
            logic [END_W-1:0] check_end;
            int idx;
            r = '0;
            idx = -1;
            case (op)
                OP_ADD:
                begin
                    n_add++;
                    if (used < REGIONS_DEFAULT) begin
                        starts[used] = addr;
                        lengths[used] = len;
                        used++;
                        if (used > peak) peak = used;
                    end else begin
                        r.dropped = 1'b1;
                        n_dropped++;
                    end
                end
                OP_REMOVE:
                begin
                    n_remove++;
                    for (int i = 0; i < used; i++) begin
                        if (idx < 0 && starts[i] == addr) idx = i;
                    end
                    if (idx >= 0) begin
                        for (int j = idx; j + 1 < used; j++) begin
                            starts[j] = starts[j + 1];
                            lengths[j] = lengths[j + 1];
                        end
                        used--;
                        r.gone = 1'b1;
                        n_removed++;
                    end
                end
                OP_CHECK:
                begin
                    n_check++;
                    check_total++;
                    // Both ends are exact 49-bit sums, so nothing wraps at the top.
                    check_end = {1'b0, addr} + {1'b0, len};
                    for (int i = 0; i < used; i++) begin
                        if (addr >= starts[i] &&
                            check_end <= {1'b0, starts[i]} + {1'b0, lengths[i]})
                            r.hit = 1'b1;
                    end
                    if (r.hit) hit_total++;
                end
                default:
                begin
                    n_noop++;
                end
            endcase
            r.count = used[COUNT_OUT_W-1:0];
            r.seen = check_total;
            r.hits = hit_total;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(region_result_t got);
            region_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no command outstanding, expected none, actual %0h",
                         $time, got);
            end else begin
                want = expected_q.pop_front();
                compare_field("in_region", 64'(want.hit), 64'(got.hit));
                compare_field("add_dropped", 64'(want.dropped), 64'(got.dropped));
                compare_field("removed", 64'(want.gone), 64'(got.gone));
                compare_field("region_count", 64'(want.count), 64'(got.count));
                compare_field("checks_seen", want.seen, got.seen);
                compare_field("checks_hit", want.hits, got.hits);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [OP_W-1:0]        operation = OP_NONE;
    logic [ADDR_W-1:0]      address = '0;
    logic [ADDR_W-1:0]      length = '0;
    logic                   done;
    logic                   in_region;
    logic                   add_dropped;
    logic                   removed;
    logic [COUNT_OUT_W-1:0] region_count;
    logic [TOTAL_W-1:0]     checks_seen;
    logic [TOTAL_W-1:0]     checks_hit;

    region_scoreboard sb;

    address_region_table_checker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .address      (address),
        .length       (length),
        .done         (done),
        .in_region    (in_region),
        .add_dropped  (add_dropped),
        .removed      (removed),
        .region_count (region_count),
        .checks_seen  (checks_seen),
        .checks_hit   (checks_hit)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({in_region, add_dropped, removed, region_count,
                             checks_seen, checks_hit});
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Most addresses fall in a narrow window so that regions overlap and checks hit.
    function automatic logic [ADDR_W-1:0] rand_addr();
        if ($urandom_range(0, 4) == 0)
            return ADDR_W'(rand64());
        return 48'h0000_0012_0000 + ADDR_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [ADDR_W-1:0] rand_len();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2)
            return ADDR_W'(rand64());
        if (roll < 4)
            return '0;
        return ADDR_W'($urandom_range(0, 2048));
    endfunction

    function automatic int pick_gap(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    task automatic issue(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                         input logic [ADDR_W-1:0] len, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        address <= addr;
        length <= len;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(op, addr, len);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic pick_command(input int phase, output logic [OP_W-1:0] op,
                                output logic [ADDR_W-1:0] addr,
                                output logic [ADDR_W-1:0] len);
        int roll, add_cut, remove_cut, k;
        logic [ADDR_W-1:0] s, l;
        logic [63:0] span, off, rest;
        // Even phases grow the table, odd phases shrink it.
        add_cut = (phase % 2 == 0) ? 53 : 18;
        remove_cut = (phase % 2 == 0) ? 68 : 63;
        roll = $urandom_range(0, 99);
        addr = rand_addr();
        len = rand_len();
        if (roll < 3) begin
            op = OP_NONE;
        end else if (roll < add_cut) begin
            op = OP_ADD;
        end else if (roll < remove_cut) begin
            op = OP_REMOVE;
            if (sb.used > 0 && $urandom_range(0, 3) != 0)
                addr = sb.starts[$urandom_range(0, sb.used - 1)];
        end else begin
            op = OP_CHECK;
            if (sb.used > 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, sb.used - 1);
                s = sb.starts[k];
                l = sb.lengths[k];
                case ($urandom_range(0, 3))
                    0:
                    begin
                        addr = s;
                        len = l;
                    end
                    1:
                    begin
                        span = 64'(l) + 1;
                        off = rand64() % span;
                        rest = 64'(l) - off;
                        addr = 48'(64'(s) + off);
                        len = 48'(rand64() % (rest + 1));
                    end
                    2:
                    begin
                        addr = s;
                        len = l + 1'b1;
                    end
                    default:
                    begin
                        addr = s - 1'b1;
                        len = 48'd1;
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then the unused code.
        issue(OP_CHECK, 48'h0, 48'h0, 0);
        issue(OP_REMOVE, 48'h1000, 48'h0, 0);
        issue(OP_NONE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
        // Exact fit, one past the end, and a zero-length check at the end address.
        issue(OP_ADD, 48'h1000, 48'h100, 0);
        issue(OP_CHECK, 48'h1000, 48'h100, 0);
        issue(OP_CHECK, 48'h1000, 48'h101, 0);
        issue(OP_CHECK, 48'h1100, 48'h0, 0);
        // Zero-length region.
        issue(OP_ADD, 48'h5000, 48'h0, 0);
        issue(OP_CHECK, 48'h5000, 48'h0, 0);
        // Top of the address space: the region end needs the 49th bit.
        issue(OP_ADD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
        issue(OP_CHECK, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
        issue(OP_CHECK, 48'hFFFF_FFFF_FFFF, 48'h0, 0);
        // A second entry with the same start; remove takes only the first one.
        issue(OP_ADD, 48'h1000, 48'h10, 0);
        issue(OP_REMOVE, 48'h1000, 48'h0, 0);
        issue(OP_CHECK, 48'h1000, 48'h100, 0);
        issue(OP_REMOVE, 48'h7777, 48'h0, 0);
        // Fill the table, then overflow it.
        while (sb.used < REGIONS_DEFAULT)
            issue(OP_ADD, 48'h2000 + 48'(sb.used) * 48'h40, 48'h20, 0);
        issue(OP_ADD, 48'h9000, 48'h10, 0);
        drain_results();

        for (int phase = 0; phase < 8; phase++) begin
            for (int n = 0; n < 200; n++) begin
                pick_command(phase, op, addr, len);
                issue(op, addr, len, pick_gap(phase % 3));
            end
            // Hold off the next phase until every result is back.
            drain_results();
        end

        repeat (8) @(posedge clk);
        $display("Ran %0d commands: %0d adds (%0d dropped on a full table),",
                 sb.n_add + sb.n_remove + sb.n_check + sb.n_noop, sb.n_add, sb.n_dropped);
        $display("%0d removes (%0d matched), %0d no-ops.",
                 sb.n_remove, sb.n_removed, sb.n_noop);
        $display("Range checks: %0d issued, %0d inside a region; peak table fill %0d of %0d.",
                 sb.n_check, sb.hit_total, sb.peak, REGIONS_DEFAULT);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
